/* hw/rtl/tlfc_pkg.sv */
package tlfc_pkg;

    // Sizes of the lamp map, the driver chains and the flash slots.
    localparam int MAP_DEPTH    = 128;
    localparam int GROUPS       = 3;
    localparam int FLASH1_SLOTS = 3;
    localparam int FLASH2_SLOTS = 2;

    // Register file: three 1 Hz slot pins, then two 2 Hz slot pins.
    localparam int NUM_REGS    = 5;
    localparam int FLASH2_BASE = 3;
    localparam int REG_W       = 3;

    // Pin code layout and flash timing.
    localparam logic [7:0] CODE_INVALID = 8'hFF;
    localparam int         GROUP_SHIFT  = 5;
    localparam logic [6:0] FAST_PERIOD  = 7'd25;
    localparam logic [6:0] SLOW_HALF    = 7'd50;
    localparam logic [6:0] COUNT_LAST   = 7'd99;

    // Request types.
    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_MAP  = 2'd2;

    // Set commands.
    localparam logic [2:0] CMD_OFF    = 3'd0;
    localparam logic [2:0] CMD_ON     = 3'd1;
    localparam logic [2:0] CMD_FLASH1 = 3'd2;
    localparam logic [2:0] CMD_FLASH2 = 3'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_INVALID     = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

endpackage

/* hw/rtl/telltale_led_flash_controller.sv */
// Channel  | Handshake            | Word
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_ready  | req_type, telltale_id, command, map_code,
//          |                      | normal_mode
// out      | out_valid / out_ready| is_frame, status, group0..2_word
// cfg      | cfg_we               | cfg_index, cfg_data (slot pin registers)
//
// A map write gives no word. A set command goes through map read, check and
// output load, with a scan of the five flash slots before the load for a flash
// command; a normal mode tick steps each flash slot through the shared bit
// update unit, then loads the output.
// Reset marks every map entry invalid through per-entry valid bits; no sweep.
// A waiting output word stalls only the final load; a new word is taken
// while the previous result is still waiting.
module telltale_led_flash_controller
    import tlfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [6:0]  telltale_id,
    input  logic [2:0]  command,
    input  logic [7:0]  map_code,
    input  logic        normal_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_frame,
    output logic [1:0]  status,
    output logic [31:0] group0_word,
    output logic [31:0] group1_word,
    output logic [31:0] group2_word,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int NUM_SLOTS = FLASH1_SLOTS + FLASH2_SLOTS;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [7:0]  pin_reg [NUM_REGS];
    logic [31:0] words_reg [GROUPS];
    logic [31:0] words_next [GROUPS];
    logic [MAP_DEPTH-1:0] map_vld_reg;
    logic [7:0]  map_mem [MAP_DEPTH];
    logic [7:0]  rd_data_reg;
    logic        rd_vld_reg;
    logic        id_ok_reg;
    logic [2:0]  cmd_reg;
    logic        scan_tick_reg;
    logic        do_fast_reg;
    logic        do_slow_reg;
    logic        found_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [NUM_SLOTS-1:0] en_reg;
    logic [NUM_SLOTS-1:0] ph_reg;
    logic [6:0]  tick_count_reg;
    logic [1:0]  res_status_reg;

    logic        out_valid_reg;
    logic        is_frame_reg;
    logic [1:0]  status_reg;
    logic [31:0] out_word_reg [3];

    logic        accept;
    logic [MAP_AW-1:0] map_addr;
    logic        id_ok;
    logic [7:0]  code;
    logic        code_ok;
    logic        slot_fast;
    logic        slot_active;
    logic [7:0]  slot_pin;
    logic        slot_last;
    logic        drv_en;
    logic [7:0]  drv_code;
    logic        drv_on;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign map_addr  = MAP_AW'(telltale_id);
    assign id_ok     = 9'(telltale_id) < 9'(MAP_DEPTH);

    // Stored pin code for the looked-up telltale, invalid when never mapped.
    assign code    = (id_ok_reg && rd_vld_reg) ? rd_data_reg : CODE_INVALID;
    assign code_ok = (code != CODE_INVALID)
                     && (4'(code[7:GROUP_SHIFT]) < 4'(GROUPS));

    // Slot positions: the 2 Hz slots come first, then the 1 Hz slots.
    function automatic logic [REG_W-1:0] slot_reg_index(input logic [SLOT_W-1:0] p);
        if (p < SLOT_W'(FLASH2_SLOTS))
            return REG_W'(FLASH2_BASE) + REG_W'(p);
        else
            return REG_W'(p) - REG_W'(FLASH2_SLOTS);
    endfunction

    assign slot_fast   = slot_reg < SLOT_W'(FLASH2_SLOTS);
    assign slot_pin    = pin_reg[slot_reg_index(slot_reg)];
    assign slot_active = slot_fast ? do_fast_reg : do_slow_reg;
    assign slot_last   = slot_reg == SLOT_W'(NUM_SLOTS - 1);

    // Shared bit update unit: selects the requester, then sets or clears
    // one bit of one latch word.
    always_comb
    begin
        drv_en   = 1'b0;
        drv_code = code;
        drv_on   = (cmd_reg == CMD_ON);
        if (state_reg == S_CHECK && code_ok
            && (cmd_reg == CMD_OFF || cmd_reg == CMD_ON))
        begin
            drv_en = 1'b1;
        end
        else if (state_reg == S_SCAN && scan_tick_reg && slot_active && en_reg[slot_reg])
        begin
            drv_en   = 1'b1;
            drv_code = slot_pin;
            drv_on   = ph_reg[slot_reg];
        end
    end

    always_comb
    begin
        logic [31:0] mask;
        mask = 32'(1) << drv_code[GROUP_SHIFT-1:0];
        for (int g = 0; g < GROUPS; g++)
        begin
            words_next[g] = words_reg[g];
        end
        if (drv_en && (4'(drv_code[7:GROUP_SHIFT]) < 4'(GROUPS)))
        begin
            if (drv_on)
                words_next[GRP_W'(drv_code[7:GROUP_SHIFT])] =
                    words_reg[GRP_W'(drv_code[7:GROUP_SHIFT])] | mask;
            else
                words_next[GRP_W'(drv_code[7:GROUP_SHIFT])] =
                    words_reg[GRP_W'(drv_code[7:GROUP_SHIFT])] & ~mask;
        end
    end

    // Lamp map memory: written on a map write, read while idle so that the
    // looked-up code holds for the whole command.
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_MAP && id_ok)
            map_mem[map_addr] <= map_code;
        if (state_reg == S_IDLE)
            rd_data_reg <= map_mem[map_addr];
    end

    // Sequencer, flash state, latch words and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pin_reg[0]     <= 8'd15;
            pin_reg[1]     <= 8'd14;
            pin_reg[2]     <= 8'd13;
            pin_reg[3]     <= 8'd12;
            pin_reg[4]     <= 8'd11;
            for (int g = 0; g < GROUPS; g++)
            begin
                words_reg[g] <= '0;
            end
            map_vld_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            id_ok_reg      <= 1'b0;
            cmd_reg        <= CMD_OFF;
            scan_tick_reg  <= 1'b0;
            do_fast_reg    <= 1'b0;
            do_slow_reg    <= 1'b0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            en_reg         <= '0;
            ph_reg         <= '0;
            tick_count_reg <= '0;
            res_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            is_frame_reg   <= 1'b0;
            status_reg     <= STATUS_OK;
            for (int k = 0; k < 3; k++)
            begin
                out_word_reg[k] <= '0;
            end
        end
        else
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                words_reg[g] <= words_next[g];
            end

            if (cfg_we && 4'(cfg_index) < 4'(NUM_REGS))
                pin_reg[REG_W'(cfg_index)] <= cfg_data;

            // The output load in S_DONE handles a word leaving in the same cycle.
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    rd_vld_reg <= map_vld_reg[map_addr];
                    id_ok_reg  <= id_ok;
                    cmd_reg    <= command;
                    slot_reg   <= '0;
                    found_reg  <= 1'b0;
                    if (accept)
                    begin
                        case (req_type)
                            REQ_MAP:
                            begin
                                if (id_ok)
                                    map_vld_reg[map_addr] <= 1'b1;
                            end
                            REQ_SET:
                            begin
                                state_reg <= S_CHECK;
                            end
                            REQ_TICK:
                            begin
                                if (normal_mode)
                                begin
                                    scan_tick_reg <= 1'b1;
                                    do_fast_reg   <= (tick_count_reg == 7'd0)
                                        || (tick_count_reg == FAST_PERIOD)
                                        || (tick_count_reg == 7'(2 * FAST_PERIOD))
                                        || (tick_count_reg == 7'(3 * FAST_PERIOD));
                                    do_slow_reg   <= (tick_count_reg == 7'd0)
                                        || (tick_count_reg == SLOW_HALF);
                                    if (tick_count_reg >= COUNT_LAST)
                                        tick_count_reg <= '0;
                                    else
                                        tick_count_reg <= tick_count_reg + 7'd1;
                                    state_reg <= S_SCAN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_CHECK:
                begin
                    scan_tick_reg <= 1'b0;
                    state_reg     <= S_DONE;
                    if (!code_ok)
                        res_status_reg <= STATUS_INVALID;
                    else if (cmd_reg == CMD_OFF || cmd_reg == CMD_ON)
                        res_status_reg <= STATUS_OK;
                    else if (cmd_reg == CMD_FLASH1 || cmd_reg == CMD_FLASH2)
                        state_reg <= S_SCAN;
                    else
                        res_status_reg <= STATUS_UNSUPPORTED;
                end

                S_SCAN:
                begin
                    if (scan_tick_reg)
                    begin
                        // Toggle each enabled slot that is due on this tick.
                        if (slot_active && en_reg[slot_reg])
                            ph_reg[slot_reg] <= !ph_reg[slot_reg];
                    end
                    else
                    begin
                        // Enable the first slot of the asked rate whose pin matches.
                        if (!found_reg && slot_pin == code
                            && (slot_fast == (cmd_reg == CMD_FLASH2)))
                        begin
                            en_reg[slot_reg] <= 1'b1;
                            found_reg        <= 1'b1;
                        end
                    end
                    if (slot_last)
                    begin
                        state_reg <= S_DONE;
                        if (found_reg || (slot_pin == code
                            && (slot_fast == (cmd_reg == CMD_FLASH2))))
                            res_status_reg <= STATUS_OK;
                        else
                            res_status_reg <= STATUS_UNSUPPORTED;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        is_frame_reg  <= scan_tick_reg;
                        status_reg    <= scan_tick_reg ? STATUS_OK : res_status_reg;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (k < GROUPS && scan_tick_reg)
                                out_word_reg[k] <= words_reg[GRP_W'(k)];
                            else
                                out_word_reg[k] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_frame    = is_frame_reg;
    assign status      = status_reg;
    assign group0_word = out_word_reg[0];
    assign group1_word = out_word_reg[1];
    assign group2_word = out_word_reg[2];

endmodule

/* tb/telltale_led_flash_controller_test.sv */
module telltale_led_flash_controller_test;
    import tlfc_pkg::*;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_FLASH1_SLOT0 = 3'd0;
    localparam logic [2:0] REG_FLASH1_SLOT1 = 3'd1;
    localparam logic [2:0] REG_FLASH1_SLOT2 = 3'd2;
    localparam logic [2:0] REG_FLASH2_SLOT0 = 3'd3;
    localparam logic [2:0] REG_FLASH2_SLOT1 = 3'd4;

    // Request type and command codes that the block does not act on.
    localparam logic [1:0] REQ_RESERVED      = 2'd3;
    localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd4;
    localparam logic [2:0] CMD_LAST_UNKNOWN  = 3'd7;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_WORDS   = 400;

    typedef struct packed {
        logic        is_frame;
        logic [1:0]  status;
        logic [31:0] group0;
        logic [31:0] group1;
        logic [31:0] group2;
    } lamp_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_SET;
    logic [6:0]  telltale_id = 7'd0;
    logic [2:0]  command = CMD_OFF;
    logic [7:0]  map_code = 8'd0;
    logic        normal_mode = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_frame;
    logic [1:0]  status;
    logic [31:0] group0_word;
    logic [31:0] group1_word;
    logic [31:0] group2_word;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_FLASH1_SLOT0;
    logic [7:0]  cfg_data = 8'd0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Shadow copy of the lamp controller state.
    logic [7:0]   slot_pin [NUM_REGS];
    logic [7:0]   lamp_map [MAP_DEPTH];
    logic [31:0]  chain_word [GROUPS];
    logic         slow_en [FLASH1_SLOTS];
    logic         slow_ph [FLASH1_SLOTS];
    logic         fast_en [FLASH2_SLOTS];
    logic         fast_ph [FLASH2_SLOTS];
    logic [6:0]   tick_cnt;
    lamp_result_t pending_results[$];

    telltale_led_flash_controller DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .telltale_id (telltale_id),
        .command     (command),
        .map_code    (map_code),
        .normal_mode (normal_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_frame    (is_frame),
        .status      (status),
        .group0_word (group0_word),
        .group1_word (group1_word),
        .group2_word (group2_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls at random according to the current idling phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void reset_shadow();
        slot_pin[REG_FLASH1_SLOT0] = 8'd15;
        slot_pin[REG_FLASH1_SLOT1] = 8'd14;
        slot_pin[REG_FLASH1_SLOT2] = 8'd13;
        slot_pin[REG_FLASH2_SLOT0] = 8'd12;
        slot_pin[REG_FLASH2_SLOT1] = 8'd11;
        for (int i = 0; i < MAP_DEPTH; i++)
            lamp_map[i] = CODE_INVALID;
        for (int i = 0; i < GROUPS; i++)
            chain_word[i] = 32'd0;
        for (int i = 0; i < FLASH1_SLOTS; i++)
        begin
            slow_en[i] = 1'b0;
            slow_ph[i] = 1'b0;
        end
        for (int i = 0; i < FLASH2_SLOTS; i++)
        begin
            fast_en[i] = 1'b0;
            fast_ph[i] = 1'b0;
        end
        tick_cnt = 7'd0;
    endfunction

    // Sets or clears one lamp bit; a pin in a missing chain is dropped.
    function automatic void drive_lamp(input logic [7:0] pin, input logic on);
        int grp;
        grp = pin >> GROUP_SHIFT;
        if (grp < GROUPS)
            chain_word[grp][pin[4:0]] = on;
    endfunction

    // Applies one accepted word to the shadow state and queues its result, if it gives one.
    function automatic void predict_lamp_word(input logic [1:0] req, input logic [6:0] id,
                                              input logic [2:0] cmd, input logic [7:0] code,
                                              input logic normal);
        lamp_result_t res;
        logic [7:0]   pin;
        logic         found;
        res = '0;
        found = 1'b0;
        case (req)
            REQ_MAP:
                lamp_map[id] = code;
            REQ_SET:
            begin
                pin = lamp_map[id];
                res.status = STATUS_OK;
                if (pin == CODE_INVALID || (pin >> GROUP_SHIFT) >= GROUPS)
                    res.status = STATUS_INVALID;
                else if (cmd == CMD_OFF || cmd == CMD_ON)
                    drive_lamp(pin, cmd == CMD_ON);
                else if (cmd == CMD_FLASH1)
                begin
                    // The first slot holding this pin is enabled.
                    for (int i = 0; i < FLASH1_SLOTS; i++)
                    begin
                        if (!found && slot_pin[i] == pin)
                        begin
                            slow_en[i] = 1'b1;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        res.status = STATUS_UNSUPPORTED;
                end
                else if (cmd == CMD_FLASH2)
                begin
                    for (int i = 0; i < FLASH2_SLOTS; i++)
                    begin
                        if (!found && slot_pin[FLASH2_BASE + i] == pin)
                        begin
                            fast_en[i] = 1'b1;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        res.status = STATUS_UNSUPPORTED;
                end
                else
                    res.status = STATUS_UNSUPPORTED;
                pending_results.push_back(res);
            end
            REQ_TICK:
            begin
                if (normal)
                begin
                    // Fast slots step four times per period, slow slots twice.
                    if (tick_cnt % FAST_PERIOD == 7'd0)
                    begin
                        for (int i = 0; i < FLASH2_SLOTS; i++)
                        begin
                            if (fast_en[i])
                            begin
                                drive_lamp(slot_pin[FLASH2_BASE + i], fast_ph[i]);
                                fast_ph[i] = !fast_ph[i];
                            end
                        end
                    end
                    if (tick_cnt == 7'd0 || tick_cnt == SLOW_HALF)
                    begin
                        for (int i = 0; i < FLASH1_SLOTS; i++)
                        begin
                            if (slow_en[i])
                            begin
                                drive_lamp(slot_pin[i], slow_ph[i]);
                                slow_ph[i] = !slow_ph[i];
                            end
                        end
                    end
                    tick_cnt = (tick_cnt >= COUNT_LAST) ? 7'd0 : tick_cnt + 7'd1;
                    res.is_frame = 1'b1;
                    res.group0 = chain_word[0];
                    res.group1 = chain_word[1];
                    res.group2 = chain_word[2];
                    pending_results.push_back(res);
                end
            end
            default:
                ;
        endcase
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Each word leaving the block is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        lamp_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("word with nothing expected: frame %b status %0d",
                             is_frame, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("is_frame", 32'(want.is_frame), 32'(is_frame));
                check_field("status", 32'(want.status), 32'(status));
                check_field("group0_word", want.group0, group0_word);
                check_field("group1_word", want.group1, group1_word);
                check_field("group2_word", want.group2, group2_word);
            end
        end
    end

    // Offers one word, holding it until the block takes it.
    task automatic send_word(input logic [1:0] req, input logic [6:0] id,
                             input logic [2:0] cmd, input logic [7:0] code,
                             input logic normal);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        telltale_id <= id;
        command     <= cmd;
        map_code    <= code;
        normal_mode <= normal;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_lamp_word(req, id, cmd, code, normal);
    endtask

    // Map writes and ignored ticks give no word, so a margin follows the drain.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slot_pin(input logic [2:0] index, input logic [7:0] pin);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= pin;
        @(posedge clk);
        slot_pin[index] = pin;
    endtask

    task automatic load_slot_pins(input logic [7:0] p0, input logic [7:0] p1,
                                  input logic [7:0] p2, input logic [7:0] p3,
                                  input logic [7:0] p4);
        write_slot_pin(REG_FLASH1_SLOT0, p0);
        write_slot_pin(REG_FLASH1_SLOT1, p1);
        write_slot_pin(REG_FLASH1_SLOT2, p2);
        write_slot_pin(REG_FLASH2_SLOT0, p3);
        write_slot_pin(REG_FLASH2_SLOT1, p4);
        cfg_we <= 1'b0;
    endtask

    // Pin code in an existing chain, or anything at all now and then.
    function automatic logic [7:0] pick_pin();
        logic [2:0] grp;
        logic [4:0] pos;
        grp = 3'($urandom_range(0, GROUPS - 1));
        pos = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 75)
            return {grp, pos};
        return 8'($urandom_range(0, 255));
    endfunction

    // A slot pin in about 45 percent of cases, so that flash commands find their slot.
    function automatic logic [7:0] pick_map_code();
        if ($urandom_range(0, 99) < 45)
            return slot_pin[$urandom_range(0, NUM_REGS - 1)];
        return pick_pin();
    endfunction

    function automatic logic [2:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return CMD_FLASH1;
        if (roll < 50)
            return CMD_FLASH2;
        if (roll < 70)
            return CMD_ON;
        if (roll < 88)
            return CMD_OFF;
        return 3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
    endfunction

    task automatic load_random_pins();
        logic [7:0] p0, p1, p2, p3, p4;
        p0 = pick_pin();
        p1 = ($urandom_range(0, 9) == 0) ? p0 : pick_pin();
        p2 = pick_pin();
        p3 = ($urandom_range(0, 9) == 0) ? p0 : pick_pin();
        p4 = ($urandom_range(0, 9) == 0) ? p3 : pick_pin();
        load_slot_pins(p0, p1, p2, p3, p4);
    endtask

    // Sends random words until the given number have had an effect.
    task automatic send_random_words(input int count);
        int         done;
        int         roll;
        logic [1:0] req;
        logic [6:0] id;
        logic [7:0] code;
        logic       normal;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            id = ($urandom_range(0, 99) < 75) ? 7'($urandom_range(0, 15))
                                              : 7'($urandom_range(0, 127));
            code = 8'($urandom_range(0, 255));
            normal = ($urandom_range(0, 9) != 0);
            if (roll < 40)
                req = REQ_TICK;
            else if (roll < 68)
                req = REQ_SET;
            else if (roll < 96)
            begin
                req = REQ_MAP;
                code = pick_map_code();
            end
            else
                req = REQ_RESERVED;
            send_word(req, id, pick_command(), code, normal);
            if (req != REQ_RESERVED && !(req == REQ_TICK && !normal))
                done++;
        end
    endtask

    // Directed words with the reset slot pins: every command and special case.
    task automatic test_directed_words();
        send_word(REQ_SET, 7'd0, CMD_ON, 8'h00, 1'b1);
        send_word(REQ_TICK, 7'd0, CMD_OFF, 8'h00, 1'b0);
        send_word(REQ_RESERVED, 7'd127, CMD_LAST_UNKNOWN, 8'hFF, 1'b1);
        send_word(REQ_MAP, 7'd0, CMD_OFF, 8'd15, 1'b1);
        send_word(REQ_MAP, 7'd127, CMD_OFF, 8'h5F, 1'b1);
        send_word(REQ_MAP, 7'd1, CMD_OFF, 8'h60, 1'b1);
        send_word(REQ_MAP, 7'd2, CMD_OFF, 8'd12, 1'b1);
        send_word(REQ_MAP, 7'd3, CMD_OFF, 8'h20, 1'b1);
        send_word(REQ_MAP, 7'd4, CMD_OFF, 8'd11, 1'b1);
        send_word(REQ_MAP, 7'd5, CMD_OFF, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd127, CMD_ON, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd5, CMD_ON, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd3, CMD_ON, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd3, CMD_OFF, 8'h00, 1'b1);
        // A pin in a chain that does not exist is rejected.
        send_word(REQ_SET, 7'd1, CMD_ON, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd0, CMD_FLASH1, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd2, CMD_FLASH2, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd4, CMD_FLASH2, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd127, CMD_FLASH1, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd3, CMD_FLASH2, 8'h00, 1'b1);
        send_word(REQ_SET, 7'd0, CMD_FIRST_UNKNOWN, 8'h00, 1'b1);
        // Turning a flashing lamp off leaves the flashing running.
        send_word(REQ_SET, 7'd0, CMD_OFF, 8'h00, 1'b1);
        send_word(REQ_TICK, 7'd0, CMD_OFF, 8'h00, 1'b1);
        send_word(REQ_TICK, 7'd0, CMD_OFF, 8'h00, 1'b1);
        send_word(REQ_MAP, 7'd127, CMD_OFF, CODE_INVALID, 1'b1);
        send_word(REQ_SET, 7'd127, CMD_ON, 8'h00, 1'b1);
        wait_until_idle();
    endtask

    // Slot pins at the extremes, then a mix of missing chains and duplicates.
    task automatic test_slot_extremes();
        load_slot_pins(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_random_words(100);
        wait_until_idle();
        load_slot_pins(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_random_words(100);
        wait_until_idle();
        load_slot_pins(8'h5F, 8'h7F, 8'h5F, 8'hE0, 8'h3F);
        send_random_words(100);
        wait_until_idle();
    endtask

    // Random traffic under each idling phase, with new slot pins per phase.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 25;
                    recv_stall_pct = 25;
                end
            endcase
            load_random_pins();
            send_random_words(PHASE_WORDS);
            wait_until_idle();
        end
    endtask

    initial
    begin
        reset_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_words();
        test_slot_extremes();
        test_random_traffic();
        wait_until_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/tlfc_pkg.sv
hw/rtl/telltale_led_flash_controller.sv
tb/telltale_led_flash_controller_test.sv
